### design/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

  // Sequencer states of the exponentiation loop.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_t;

  // Register file address width; register index sits above the byte offset.
  localparam int ADDR_WIDTH = 4;

  // Value of the modulus register after reset, truncated to the modulus width.
  localparam logic [63:0] MODULUS_RESET = 64'd7919;

endpackage

`default_nettype wire

### design/modexp_mulmod.sv
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial modular multiplier: r = (a * b) mod m, one multiplier bit per
// cycle, most significant bit first. Requires a < m and m > 1; b may be any
// value, so it also reduces b modulo m when a is one.
module modexp_mulmod #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic              done,
  output logic [W-1:0]      r
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     mplr;
  logic [W-1:0]     acc;
  logic [W-1:0]     acc_next;
  logic [W+1:0]     sum;
  logic [W+1:0]     m1;
  logic [W+1:0]     m2;

  // Double the accumulator and add a when the current multiplier bit is set.
  // The sum stays below 3m, so at most two moduli come off.
  always_comb begin
    sum = {1'b0, acc, 1'b0} + {2'b00, (mplr[W-1] ? a : {W{1'b0}})};
    m1  = {2'b00, m};
    m2  = {1'b0, m, 1'b0};
    if (sum >= m2) begin
      acc_next = W'(sum - m2);
    end else if (sum >= m1) begin
      acc_next = W'(sum - m1);
    end else begin
      acc_next = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc  <= '0;
      mplr <= b;
    end else if (busy) begin
      acc  <= acc_next;
      mplr <= {mplr[W-2:0], 1'b0};
    end
  end

  assign r = acc;

  a_go_busy : assert property (@(posedge clk) disable iff (rst) go |=> busy)
    else $error("multiplier did not start");
  a_acc_range : assert property (@(posedge clk) disable iff (rst)
    busy && !go && cnt != CNT_W'(W) |-> acc < m)
    else $error("partial product left the residue range");
  a_done_pulse : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

endmodule

`default_nettype wire

### design/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Modular exponentiation unit: power_mod = base ** exponent mod modulus, by
// left-to-right square-and-multiply. A transfer is taken at the rising edge
// where start is high and busy is low; base and exponent are captured there
// and the modulus register is sampled at the same time. busy stays high until
// the result has gone out. The result appears on power_mod for exactly one
// cycle with done high, and the receiver cannot stall it, so it must take the
// value in that cycle. All work runs through one bit-serial modular multiplier.
// The base is first reduced modulo the modulus (one product), then every one
// of the EXP_WIDTH exponent bits costs a squaring, plus a multiply when the
// bit is set. A zero exponent returns 1 and a modulus of 0 or 1 with a nonzero
// exponent returns 0; both skip the multiplier and go straight to the result.
// The modulus lives in register 0 of the APB port (byte address 0), resets to
// 7919 and should only be written while busy is low.
module modular_exponentiation_unit #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 63
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [modexp_pkg::ADDR_WIDTH-1:0]     paddr,
  input  wire logic [((MOD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic      [((MOD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                                       pready,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [MOD_WIDTH-1:0]                  base,
  input  wire logic [EXP_WIDTH-1:0]                  exponent,
  output logic                                       done,
  output logic      [MOD_WIDTH-1:0]                  power_mod
);

  localparam int DATA_W    = (MOD_WIDTH > 32) ? 64 : 32;
  localparam int REG_SHIFT = (MOD_WIDTH > 32) ? 3 : 2;
  localparam int IDX_W     = $clog2(EXP_WIDTH);

  modexp_pkg::state_t state;
  modexp_pkg::state_t state_next;

  logic [MOD_WIDTH-1:0] modulus;
  logic [MOD_WIDTH-1:0] m_reg;
  logic [MOD_WIDTH-1:0] base_r;
  logic [MOD_WIDTH-1:0] base_r_next;
  logic [MOD_WIDTH-1:0] res;
  logic [MOD_WIDTH-1:0] res_next;
  logic [EXP_WIDTH-1:0] e_sh;
  logic [EXP_WIDTH-1:0] e_sh_next;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     idx_next;
  logic                 mm_go;
  logic                 mm_go_next;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_a;
  logic [MOD_WIDTH-1:0] mm_b;
  logic [MOD_WIDTH-1:0] mm_r;
  logic                 accept;
  logic                 reg_hit;
  logic                 cfg_write;
  logic                 cur_bit;
  logic                 last_bit;

  // ---------------------------------------------------------------------
  // Configuration port. Only register 0 exists; any other index reads as
  // zero and ignores writes.
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_hit   = ((paddr >> REG_SHIFT) == '0);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? DATA_W'(modulus) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= modexp_pkg::MODULUS_RESET[MOD_WIDTH-1:0];
    end else if (cfg_write) begin
      modulus <= pwdata[MOD_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  assign busy     = (state != modexp_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign cur_bit  = e_sh[EXP_WIDTH-1];
  assign last_bit = (idx == '0);

  always_comb begin
    state_next = state;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (accept) begin
          if (exponent == '0 || modulus <= MOD_WIDTH'(1)) begin
            state_next = modexp_pkg::ST_FINISH;
          end else begin
            state_next = modexp_pkg::ST_REDUCE;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (mm_done) begin
          state_next = modexp_pkg::ST_SQUARE;
        end
      end
      modexp_pkg::ST_SQUARE: begin
        if (mm_done) begin
          if (cur_bit) begin
            state_next = modexp_pkg::ST_MULT;
          end else if (last_bit) begin
            state_next = modexp_pkg::ST_FINISH;
          end
        end
      end
      modexp_pkg::ST_MULT: begin
        if (mm_done) begin
          if (last_bit) begin
            state_next = modexp_pkg::ST_FINISH;
          end else begin
            state_next = modexp_pkg::ST_SQUARE;
          end
        end
      end
      modexp_pkg::ST_FINISH: begin
        state_next = modexp_pkg::ST_IDLE;
      end
      default: begin
        state_next = modexp_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath updates and multiplier launches. A launch is registered, so go
  // reaches the multiplier in the same cycle as the state that selects its operands.
  always_comb begin
    res_next    = res;
    base_r_next = base_r;
    e_sh_next   = e_sh;
    idx_next    = idx;
    mm_go_next  = 1'b0;
    case (state)
      modexp_pkg::ST_IDLE: begin
        if (accept) begin
          base_r_next = base;
          e_sh_next   = exponent;
          idx_next    = IDX_W'(EXP_WIDTH - 1);
          if (exponent == '0) begin
            res_next = MOD_WIDTH'(1);
          end else if (modulus <= MOD_WIDTH'(1)) begin
            res_next = '0;
          end else begin
            res_next   = MOD_WIDTH'(1);
            mm_go_next = 1'b1;
          end
        end
      end
      modexp_pkg::ST_REDUCE: begin
        if (mm_done) begin
          base_r_next = mm_r;
          mm_go_next  = 1'b1;
        end
      end
      modexp_pkg::ST_SQUARE: begin
        if (mm_done) begin
          res_next = mm_r;
          if (cur_bit) begin
            mm_go_next = 1'b1;
          end else if (!last_bit) begin
            e_sh_next  = {e_sh[EXP_WIDTH-2:0], 1'b0};
            idx_next   = idx - IDX_W'(1);
            mm_go_next = 1'b1;
          end
        end
      end
      modexp_pkg::ST_MULT: begin
        if (mm_done) begin
          res_next = mm_r;
          if (!last_bit) begin
            e_sh_next  = {e_sh[EXP_WIDTH-2:0], 1'b0};
            idx_next   = idx - IDX_W'(1);
            mm_go_next = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= modexp_pkg::ST_IDLE;
      mm_go <= 1'b0;
    end else begin
      state <= state_next;
      mm_go <= mm_go_next;
    end
  end

  always_ff @(posedge clk) begin
    res    <= res_next;
    base_r <= base_r_next;
    e_sh   <= e_sh_next;
    idx    <= idx_next;
    if (accept) begin
      m_reg <= modulus;
    end
  end

  // Operand selection for the shared multiplier. During base reduction the
  // raw base is the multiplier operand and one is the multiplicand.
  always_comb begin
    case (state)
      modexp_pkg::ST_REDUCE: begin
        mm_a = MOD_WIDTH'(1);
        mm_b = base_r;
      end
      modexp_pkg::ST_MULT: begin
        mm_a = res;
        mm_b = base_r;
      end
      default: begin
        mm_a = res;
        mm_b = res;
      end
    endcase
  end

  modexp_mulmod #(
    .W(MOD_WIDTH)
  ) u_mulmod (
    .clk (clk),
    .rst (rst),
    .go  (mm_go),
    .a   (mm_a),
    .b   (mm_b),
    .m   (m_reg),
    .done(mm_done),
    .r   (mm_r)
  );

  assign done      = (state == modexp_pkg::ST_FINISH);
  assign power_mod = res;

  a_accept_busy : assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("transfer accepted but unit not busy");
  a_done_once : assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_launch_busy : assert property (@(posedge clk) disable iff (rst)
    mm_go |-> (state == modexp_pkg::ST_REDUCE || state == modexp_pkg::ST_SQUARE ||
               state == modexp_pkg::ST_MULT))
    else $error("multiplier launched outside a product step");
  a_result_range : assert property (@(posedge clk) disable iff (rst)
    done && m_reg != '0 && power_mod != MOD_WIDTH'(1) |-> power_mod < m_reg)
    else $error("result not reduced modulo the modulus");

endmodule

`default_nettype wire

### tb/modular_exponentiation_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the modular exponentiation unit.
//
// The bench drives base/exponent transfers on the start/busy command port and
// configures the modulus through the APB port. Every accepted transfer gets an
// answer, typed in or from a local square-and-multiply model, and it is queued. Each
// strobed result on power_mod is then compared with the oldest queued answer.
// The receiver cannot stall the block, so the monitor takes a result in the
// cycle where done is high.
//
// The run has two parts. A directed list comes first. It covers the reset
// modulus, zero and maximal fields, a base equal to the modulus, moduli of 0,
// 1, 2, 2**31 and 2**32-1, a write to an unmapped register, and read-back of
// the modulus. Rows whose answer is obvious carry it typed in, and the other
// rows use the model. Several random phases follow. Each phase sets a
// different modulus, and the sender idling changes from phase to phase.
module modular_exponentiation_unit_test;

  localparam int MOD_W = 32;
  localparam int EXP_W = 63;
  localparam int DATA_W = 32;
  localparam int ADDR_W = modexp_pkg::ADDR_WIDTH;
  localparam logic [MOD_W-1:0] MODULUS_INIT = modexp_pkg::MODULUS_RESET[MOD_W-1:0];

  // Register map: only the modulus is implemented, and the other indexes in
  // the address space must ignore writes.
  localparam int REG_MODULUS = 0;
  localparam int REG_COUNT = 1;
  localparam int REG_LAST_INDEX = (1 << (ADDR_W - 2)) - 1;

  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 17;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 100;
  // The limit covers about 140 transfers with sender gaps, with a wide margin.
  localparam int CYCLE_LIMIT = 3_000_000;

  localparam int IDLE_SENDER_PCT = 62;
  localparam int IDLE_BOTH_PCT = 25;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_READ,
    ROW_ITEM
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [3:0]        reg_index;
    logic [DATA_W-1:0] wdata;
    logic [MOD_W-1:0]  base_val;
    logic [EXP_W-1:0]  exp_val;
    logic              known;
    logic [MOD_W-1:0]  answer;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  start = 1'b0;
  logic                  busy;
  logic [MOD_W-1:0]      base = '0;
  logic [EXP_W-1:0]      exponent = '0;
  logic                  done;
  logic [MOD_W-1:0]      power_mod;

  // Answers waiting for their result, in transfer order.
  logic [MOD_W-1:0] pending_power[$];
  // One entry per issued transfer: {typed answer present, typed answer}.
  logic [MOD_W:0]   typed_answers[$];
  stim_row_t        directed_rows[$];

  logic [MOD_W-1:0] modulus_now = MODULUS_INIT;
  int unsigned      idle_pct = 0;
  int unsigned      items_sent = 0;
  int unsigned      results_seen = 0;
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      modulus_writes = 0;
  int unsigned      directed_items = 0;

  modular_exponentiation_unit DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .start(start),
    .busy(busy),
    .base(base),
    .exponent(exponent),
    .done(done),
    .power_mod(power_mod)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Left-to-right square-and-multiply. Operands stay below the modulus, so a
  // 64-bit product never overflows before it is reduced.
  function automatic logic [MOD_W-1:0] expected_power(input logic [MOD_W-1:0] b,
                                                      input logic [EXP_W-1:0] e,
                                                      input logic [MOD_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] b_red;
    if (e == '0) return MOD_W'(1);
    if (m <= 1) return '0;
    b_red = {32'd0, b} % {32'd0, m};
    acc = 64'd1;
    for (int i = EXP_W - 1; i >= 0; i--) begin
      acc = (acc * acc) % {32'd0, m};
      if (e[i]) acc = (acc * b_red) % {32'd0, m};
    end
    return acc[MOD_W-1:0];
  endfunction

  task automatic log_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  function automatic stim_row_t item_row(input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e,
                                         input logic known, input logic [MOD_W-1:0] answer);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.base_val = b;
    r.exp_val = e;
    r.known = known;
    r.answer = answer;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input row_kind_t kind, input int unsigned index,
                                        input logic [DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = kind;
    r.reg_index = index[3:0];
    r.wdata = data;
    return r;
  endfunction

  // Appends one row to the directed list.
  function automatic void add_row(input stim_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // Monitor. It works at every rising edge on the values that held just
  // before the edge. It checks strobed results, queues the answer for each
  // accepted transfer, and follows writes to the modulus register.
  always @(posedge clk) begin
    logic [MOD_W-1:0] want;
    logic [MOD_W:0]   typed;
    if (rst) begin
      modulus_now = MODULUS_INIT;
    end else begin
      if (done) begin
        results_seen++;
        if (pending_power.size() == 0) begin
          log_error($sformatf("result %0h with no transfer outstanding", power_mod));
        end else begin
          want = pending_power.pop_front();
          if (power_mod !== want)
            log_error($sformatf("power_mod of result %0d: expected %0h, got %0h",
                                results_seen, want, power_mod));
        end
      end
      if (start && !busy) begin
        typed = (typed_answers.size() != 0) ? typed_answers.pop_front() : '0;
        if (typed[MOD_W]) pending_power = {pending_power, typed[MOD_W-1:0]};
        else pending_power = {pending_power, expected_power(base, exponent, modulus_now)};
      end
      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_MODULUS) begin
        modulus_now = pwdata[MOD_W-1:0];
        modulus_writes++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d of %0d results in", cycle_count,
               results_seen, items_sent);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Setup cycle, then access cycle. A read is checked at the edge that ends
  // the access. Only a read of the modulus is checked. psel then drops before
  // the next access, so it starts cleanly with its own setup cycle.
  task automatic apb_access(input logic is_write, input int unsigned index,
                            input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= ADDR_W'(index << 2);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!is_write && index == REG_MODULUS && prdata[MOD_W-1:0] !== modulus_now)
      log_error($sformatf("modulus read-back: expected %0h, got %0h", modulus_now, prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Issues one transfer and returns at the edge where it is accepted. When no
  // idling is asked for, start stays high, so the next transfer goes in at
  // the first edge where busy is low. Otherwise start drops and the bench
  // waits for busy to fall. It then idles for a random number of cycles. This
  // moves the point where start rises against the end of the previous job.
  task automatic issue_item(input logic [MOD_W-1:0] b, input logic [EXP_W-1:0] e,
                            input logic known, input logic [MOD_W-1:0] answer);
    if (idle_pct != 0) begin
      start <= 1'b0;
      do @(posedge clk); while (busy);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    typed_answers = {typed_answers, {known, answer}};
    base <= b;
    exponent <= e;
    start <= 1'b1;
    items_sent++;
    do @(posedge clk); while (busy);
  endtask

  // Brings the block to idle before a register access or the end of the run.
  // Every transfer gives a result, so the result count is enough to tell when
  // all work is done.
  task automatic wait_idle();
    start <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    stim_row_t        row;
    logic [MOD_W-1:0] b;
    logic [EXP_W-1:0] e;
    logic [MOD_W-1:0] m;
    int unsigned      idle_by_phase[4];

    // The receiver cannot stall, so its stall phase reduces to a phase with
    // no idling.
    idle_by_phase = '{0, IDLE_SENDER_PCT, 0, IDLE_BOTH_PCT};

    // Reset modulus 7919 is prime, so Fermat gives a typed answer.
    add_row(item_row(32'd0, 63'd0, 1'b1, 32'd1));
    add_row(item_row(32'd5, 63'd1, 1'b1, 32'd5));
    add_row(item_row(32'd2, 63'd10, 1'b1, 32'd1024));
    add_row(item_row(32'd7919, 63'd5, 1'b1, 32'd0));
    add_row(item_row(32'd7920, 63'd1, 1'b1, 32'd1));
    add_row(item_row(32'd12345, 63'd7918, 1'b1, 32'd1));
    add_row(item_row(32'd0, 63'd3, 1'b1, 32'd0));
    add_row(item_row('1, '1, 1'b0, '0));
    // A write to an unmapped register must leave the modulus alone.
    add_row(reg_row(ROW_WRITE, REG_COUNT, 32'd3));
    add_row(reg_row(ROW_READ, REG_MODULUS, '0));
    add_row(item_row(32'd10, 63'd1, 1'b1, 32'd10));
    // A modulus of one gives 1 for a zero exponent and 0 otherwise.
    add_row(reg_row(ROW_WRITE, REG_MODULUS, 32'd1));
    add_row(item_row(32'd9, 63'd0, 1'b1, 32'd1));
    add_row(item_row(32'd9, 63'd5, 1'b1, 32'd0));
    // A modulus of zero lies outside the legal range but is still defined.
    add_row(reg_row(ROW_WRITE, REG_MODULUS, 32'd0));
    add_row(reg_row(ROW_READ, REG_MODULUS, '0));
    add_row(item_row('1, 63'd0, 1'b1, 32'd1));
    add_row(item_row(32'd3, 63'd1, 1'b1, 32'd0));
    // Largest modulus: 2**32-2 is -1, and 2**63-1 is odd.
    add_row(reg_row(ROW_WRITE, REG_MODULUS, 32'hFFFF_FFFF));
    add_row(reg_row(ROW_READ, REG_MODULUS, '0));
    add_row(item_row(32'hFFFF_FFFE, 63'd2, 1'b1, 32'd1));
    add_row(item_row(32'hFFFF_FFFF, 63'd7, 1'b1, 32'd0));
    add_row(item_row(32'hFFFF_FFFE, '1, 1'b1, 32'hFFFF_FFFE));
    add_row(item_row(32'h8000_0000, 63'h4000_0000_0000_0000, 1'b0, '0));
    add_row(item_row(32'hDEAD_BEEF, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0));
    add_row(reg_row(ROW_WRITE, REG_MODULUS, 32'd2));
    add_row(item_row(32'd3, 63'd100, 1'b1, 32'd1));
    add_row(item_row(32'd4, 63'd1, 1'b1, 32'd0));
    add_row(reg_row(ROW_WRITE, REG_MODULUS, 32'h8000_0000));
    add_row(item_row(32'd2, 63'd31, 1'b1, 32'd0));
    add_row(item_row(32'd3, 63'h5555_5555_5555_5555, 1'b0, '0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_ITEM) begin
        issue_item(row.base_val, row.exp_val, row.known, row.answer);
        directed_items++;
      end else begin
        wait_idle();
        apb_access(row.kind == ROW_WRITE, row.reg_index, row.wdata);
      end
    end

    // Random phases. Each phase sets its own modulus, and the phases cover
    // the extremes and the fast paths. The sender idling changes from phase
    // to phase.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: m = 32'hFFFF_FFFF;
        1: m = $urandom_range(2, 300);
        2: m = $urandom_range(0, 1);
        3: m = $urandom;
        4: m = $urandom | 32'h8000_0000;
        5: m = 32'hFFFF_FFFB;
        default: m = MODULUS_INIT;
      endcase
      if ($urandom_range(0, 1) == 1)
        apb_access(1'b1, $urandom_range(REG_COUNT, REG_LAST_INDEX), $urandom);
      apb_access(1'b1, REG_MODULUS, m);
      apb_access(1'b0, REG_MODULUS, '0);
      idle_pct = idle_by_phase[phase % 4];

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        case ($urandom_range(0, 4))
          0: b = $urandom_range(0, 15);
          1: b = '1;
          2: b = modulus_now * $urandom_range(0, 3);
          default: b = $urandom;
        endcase
        case ($urandom_range(0, 9))
          0: e = '0;
          1: e = '1;
          2: e = EXP_W'(64'd1 << $urandom_range(0, EXP_W - 1));
          3, 4: e = $urandom_range(1, 64);
          default: e = EXP_W'({$urandom, $urandom});
        endcase
        issue_item(b, e, 1'b0, '0);
      end
    end

    idle_pct = 0;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_power.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_power.size()));

    $display("Covered %0d directed and %0d random transfers over %0d modulus writes,",
             directed_items, items_sent - directed_items, modulus_writes);
    $display("with %0d results checked and %0d mismatches in %0d cycles.",
             results_seen, error_count, cycle_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
design/modexp_pkg.sv
design/modexp_mulmod.sv
design/modular_exponentiation_unit.sv
tb/modular_exponentiation_unit_test.sv
